// File: rtl/pnf_pkg.sv
`default_nettype none

package pnf_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = 8;
   localparam int COORD_W    = 32;
   localparam int FREQ_W     = 24;
   localparam int AMP_W      = 17;
   localparam int FADE_W     = 17;
   localparam int POLY_W     = 21;
   localparam int GRAD_W     = 19;
   localparam int LERP_W     = 22;
   localparam int PROD_W     = AMP_W + 1 + LERP_W;
   localparam int QUO_W      = 18;
   localparam int OUT_W      = 16;
   localparam int PAR_W      = 16;

   localparam logic [FREQ_W-1:0] FREQ_ONE = 24'h01_0000;
   localparam logic [FREQ_W-1:0] FREQ_MAX = 24'hFF_FFFF;
   localparam logic [AMP_W-1:0]  AMP_ONE  = 17'h1_0000;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_OCTAVES = 2'd0,
      CSR_PERSIST = 2'd1,
      CSR_LACUN   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // one octave of one sample entering the noise pipeline
   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic [FREQ_W-1:0]         freq;
      logic [AMP_W-1:0]          amp;
      logic                      first;
      logic                      last;
   } oct_type;

   // weighted octave leaving the noise pipeline
   typedef struct packed {
      logic signed [PROD_W-1:0] prod;
      logic [AMP_W-1:0]         amp;
      logic                     first;
      logic                     last;
   } tail_type;

   function automatic logic signed [GRAD_W-1:0] grad_q16(
      input logic [3:0]         h,
      input logic signed [16:0] x,
      input logic signed [16:0] y,
      input logic signed [16:0] z
   );
      logic signed [GRAD_W-1:0] a;
      logic signed [GRAD_W-1:0] b;
      a = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
      b = (h < 4'd4) ? GRAD_W'(y) :
          ((h == 4'd12 || h == 4'd14) ? GRAD_W'(x) : GRAD_W'(z));
      if (h[0]) a = -a;
      if (h[1]) b = -b;
      return a + b;
   endfunction

   // a + floor((b - a) * w / 2^16)
   function automatic logic signed [LERP_W-1:0] lerp_q16(
      input logic signed [LERP_W-1:0] a,
      input logic signed [LERP_W-1:0] b,
      input logic [FADE_W-1:0]        w
   );
      logic signed [LERP_W:0]          diff;
      logic signed [LERP_W+FADE_W+1:0] prod;
      logic signed [LERP_W+FADE_W+1:0] sh;
      diff = {b[LERP_W-1], b} - {a[LERP_W-1], a};
      prod = diff * $signed({1'b0, w});
      sh   = prod >>> 16;
      return a + sh[LERP_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/pnf_divider.sv
`default_nettype none

module pnf_divider #(
   parameter int NUM_W = 44,
   parameter int DEN_W = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    busy,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [15:0]      quotient
);
   import pnf_pkg::*;

   localparam int DW    = DEN_W + 2;
   localparam int STEPS = QUO_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(32767);
   localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(32768);

   div_state_type state_ff, state_in;
   logic [DW:0]             rem_ff, rem_in;
   logic [QUO_W-1:0]        low_ff, low_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [DW-1:0]           d_ff, d_in;
   logic                    neg_ff, neg_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    ov_ff, ov_in;
   logic signed [OUT_W-1:0] q_ff, q_in;

   logic [NUM_W-1:0]        mag;
   logic [DW:0]             r;
   logic [DW:0]             r2;
   logic [QUO_W-1:0]        l;
   logic [QUO_W-1:0]        qv;
   logic signed [OUT_W-1:0] sat;

   always_comb begin
      mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

      if (neg_ff) begin
         sat = (quo_ff > NEG_LIM) ? 16'sh8000 : -$signed(OUT_W'(quo_ff));
      end else begin
         sat = (quo_ff > POS_LIM) ? 16'sh7FFF : $signed(OUT_W'(quo_ff));
      end

      state_in = state_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      d_in     = d_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      ov_in    = ov_ff && !out_ready;
      r        = rem_ff;
      r2       = rem_ff;
      l        = low_ff;
      qv       = quo_ff;

      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               rem_in   = (DW + 1)'(mag >> QUO_W);
               low_in   = mag[QUO_W-1:0];
               quo_in   = '0;
               d_in     = {den, 2'b00};
               neg_in   = num[NUM_W-1];
               cnt_in   = CNT_W'(STEPS);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            // two restoring steps per cycle
            for (int s = 0; s < 2; s++) begin
               r2 = {r[DW-1:0], l[QUO_W-1]};
               l  = l << 1;
               if (r2 >= {1'b0, d_ff}) begin
                  r  = r2 - {1'b0, d_ff};
                  qv = {qv[QUO_W-2:0], 1'b1};
               end else begin
                  r  = r2;
                  qv = {qv[QUO_W-2:0], 1'b0};
               end
            end
            rem_in = r;
            low_in = l;
            quo_in = qv;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) state_in = DIV_DONE;
         end
         DIV_DONE: begin
            if (!ov_ff || out_ready) begin
               ov_in    = 1'b1;
               q_in     = sat;
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
   end

   assign busy      = (state_ff != DIV_IDLE);
   assign out_valid = ov_ff;
   assign quotient  = q_ff;

endmodule

`default_nettype wire

// File: rtl/pnf_noise_pipe.sv
`default_nettype none

module pnf_noise_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              load_en,
   input  logic [7:0]        load_index,
   input  logic [7:0]        load_value,
   input  logic              cmd_valid,
   input  pnf_pkg::oct_type  cmd,
   output logic              reads_pending,
   output logic              tail_valid,
   output pnf_pkg::tail_type tail
);
   import pnf_pkg::*;

   localparam int NUM_PORTS  = 14;
   localparam int NUM_COPIES = NUM_PORTS / 2;
   localparam int STAGES     = 9;

   logic [STAGES:1] vld_ff, vld_in;

   logic [AMP_W-1:0] sb_amp_ff   [1:STAGES];
   logic             sb_first_ff [1:STAGES];
   logic             sb_last_ff  [1:STAGES];

   // table read ports
   logic [TABLE_SIZE-1:0] pvld_ff;
   logic [IDX_W-1:0]      rd_addr [NUM_PORTS];
   logic [IDX_W-1:0]      rd_data [NUM_PORTS];
   logic [IDX_W-1:0]      rd_val  [NUM_PORTS];
   logic                  rv_ff   [NUM_PORTS];
   logic [IDX_W-1:0]      ra_ff   [NUM_PORTS];

   logic signed [COORD_W-1:0]        crd [3];
   logic signed [COORD_W+FREQ_W:0]   prd [3];
   logic [47:0]                      t3_full [3];
   logic [36:0]                      poly_full [3];
   logic [36:0]                      fade_full [3];
   logic [IDX_W-1:0]                 ha, hb, hq;
   logic signed [16:0]               ox, oy, oz;
   int                               port;

   logic [15:0]       s1_f_ff [3], s1_f_in [3];
   logic [IDX_W-1:0]  s1_i_ff [3], s1_i_in [3];
   logic [15:0]       s2_f_ff [3];
   logic [31:0]       s2_t2_ff [3], s2_t2_in [3];
   logic [IDX_W-1:0]  s2_yi_ff, s2_zi_ff;
   logic [15:0]       s3_f_ff [3];
   logic [15:0]       s3_t3_ff [3], s3_t3_in [3];
   logic [POLY_W-1:0] s3_poly_ff [3], s3_poly_in [3];
   logic [IDX_W-1:0]  s3_zi_ff;
   logic [15:0]       s4_f_ff [3];
   logic [FADE_W-1:0] s4_fade_ff [3], s4_fade_in [3];
   logic signed [GRAD_W-1:0] s5_g_ff [8], s5_g_in [8];
   logic [FADE_W-1:0] s5_fade_ff [3];
   logic signed [LERP_W-1:0] s6_e_ff [4], s6_e_in [4];
   logic [FADE_W-1:0] s6_v_ff, s6_w_ff;
   logic signed [LERP_W-1:0] s7_lo_ff, s7_lo_in, s7_hi_ff, s7_hi_in;
   logic [FADE_W-1:0] s7_w_ff;
   logic signed [LERP_W-1:0] s8_n_ff, s8_n_in;
   logic signed [PROD_W-1:0] s9_prod_ff, s9_prod_in;

   always_comb begin
      vld_in = {vld_ff[STAGES-1:1], cmd_valid};
      crd[0] = cmd.cx;
      crd[1] = cmd.cy;
      crd[2] = cmd.cz;

      for (int p = 0; p < NUM_PORTS; p++) begin
         rd_val[p] = rv_ff[p] ? rd_data[p] : ra_ff[p];
      end

      for (int a = 0; a < 3; a++) begin
         prd[a]        = crd[a] * $signed({1'b0, cmd.freq});
         s1_f_in[a]    = prd[a][31:16];
         s1_i_in[a]    = prd[a][39:32];
         s2_t2_in[a]   = 32'(s1_f_ff[a]) * 32'(s1_f_ff[a]);
         t3_full[a]    = 48'(s2_t2_ff[a]) * 48'(s2_f_ff[a]);
         s3_t3_in[a]   = t3_full[a][47:32];
         poly_full[a]  = 37'(s2_t2_ff[a]) * 37'd6 + (37'd10 << 32)
                       - ((37'(s2_f_ff[a]) * 37'd15) << 16);
         s3_poly_in[a] = poly_full[a][36:16];
         fade_full[a]  = 37'(s3_t3_ff[a]) * 37'(s3_poly_ff[a]);
         s4_fade_in[a] = fade_full[a][32:16];
      end

      // hash chain: x cell, then y, then z
      rd_addr[0] = s1_i_ff[0];
      rd_addr[1] = s1_i_ff[0] + 8'd1;
      ha = rd_val[0] + s2_yi_ff;
      hb = rd_val[1] + s2_yi_ff;
      rd_addr[2] = ha;
      rd_addr[3] = ha + 8'd1;
      rd_addr[4] = hb;
      rd_addr[5] = hb + 8'd1;
      hq = '0;
      for (int q = 0; q < 4; q++) begin
         hq = rd_val[2 + q] + s3_zi_ff;
         rd_addr[6 + 2 * q] = hq;
         rd_addr[7 + 2 * q] = hq + 8'd1;
      end

      // corner j: bit 0 picks x+1, bit 1 y+1, bit 2 z+1
      ox = '0;
      oy = '0;
      oz = '0;
      port = 0;
      for (int j = 0; j < 8; j++) begin
         port = 6 + 4 * (j & 1) + 2 * ((j >> 1) & 1) + (j >> 2);
         ox = $signed({((j & 1) != 0), s4_f_ff[0]});
         oy = $signed({(((j >> 1) & 1) != 0), s4_f_ff[1]});
         oz = $signed({((j >> 2) != 0), s4_f_ff[2]});
         s5_g_in[j] = grad_q16(rd_val[port][3:0], ox, oy, oz);
      end

      for (int k = 0; k < 4; k++) begin
         s6_e_in[k] = lerp_q16(LERP_W'(s5_g_ff[2 * k]), LERP_W'(s5_g_ff[2 * k + 1]),
                               s5_fade_ff[0]);
      end
      s7_lo_in   = lerp_q16(s6_e_ff[0], s6_e_ff[1], s6_v_ff);
      s7_hi_in   = lerp_q16(s6_e_ff[2], s6_e_ff[3], s6_v_ff);
      s8_n_in    = lerp_q16(s7_lo_ff, s7_hi_ff, s7_w_ff);
      s9_prod_in = $signed({1'b0, sb_amp_ff[8]}) * s8_n_ff;
   end

   // table copies, all written together, two read ports each
   for (genvar c = 0; c < NUM_COPIES; c++) begin : g_copy
      logic [IDX_W-1:0] mem [TABLE_SIZE];
      logic [IDX_W-1:0] rd0_ff;
      logic [IDX_W-1:0] rd1_ff;

      always_ff @(posedge clock) begin
         if (load_en) mem[load_index] <= load_value;
         if (adv) begin
            rd0_ff <= mem[rd_addr[2 * c]];
            rd1_ff <= mem[rd_addr[2 * c + 1]];
         end
      end

      assign rd_data[2 * c]     = rd0_ff;
      assign rd_data[2 * c + 1] = rd1_ff;
   end

   // entries never loaded read as their own index
   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= '0;
      end else if (load_en) begin
         pvld_ff[load_index] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            rv_ff[p] <= pvld_ff[rd_addr[p]];
            ra_ff[p] <= rd_addr[p];
         end
         sb_amp_ff[1]   <= cmd.amp;
         sb_first_ff[1] <= cmd.first;
         sb_last_ff[1]  <= cmd.last;
         for (int k = 2; k <= STAGES; k++) begin
            sb_amp_ff[k]   <= sb_amp_ff[k-1];
            sb_first_ff[k] <= sb_first_ff[k-1];
            sb_last_ff[k]  <= sb_last_ff[k-1];
         end
         for (int a = 0; a < 3; a++) begin
            s1_f_ff[a]    <= s1_f_in[a];
            s1_i_ff[a]    <= s1_i_in[a];
            s2_f_ff[a]    <= s1_f_ff[a];
            s2_t2_ff[a]   <= s2_t2_in[a];
            s3_f_ff[a]    <= s2_f_ff[a];
            s3_t3_ff[a]   <= s3_t3_in[a];
            s3_poly_ff[a] <= s3_poly_in[a];
            s4_f_ff[a]    <= s3_f_ff[a];
            s4_fade_ff[a] <= s4_fade_in[a];
            s5_fade_ff[a] <= s4_fade_ff[a];
         end
         s2_yi_ff <= s1_i_ff[1];
         s2_zi_ff <= s1_i_ff[2];
         s3_zi_ff <= s2_zi_ff;
         for (int j = 0; j < 8; j++) s5_g_ff[j] <= s5_g_in[j];
         for (int k = 0; k < 4; k++) s6_e_ff[k] <= s6_e_in[k];
         s6_v_ff    <= s5_fade_ff[1];
         s6_w_ff    <= s5_fade_ff[2];
         s7_lo_ff   <= s7_lo_in;
         s7_hi_ff   <= s7_hi_in;
         s7_w_ff    <= s6_w_ff;
         s8_n_ff    <= s8_n_in;
         s9_prod_ff <= s9_prod_in;
      end
   end

   assign reads_pending = |vld_ff[3:1];
   assign tail_valid    = vld_ff[STAGES];
   assign tail.prod     = s9_prod_ff;
   assign tail.amp      = sb_amp_ff[STAGES];
   assign tail.first    = sb_first_ff[STAGES];
   assign tail.last     = sb_last_ff[STAGES];

endmodule

`default_nettype wire

// File: rtl/perlin_noise_3d_fbm_unit.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_*     in         req_valid/req_ready    op, coord_x/y/z, entry_index, entry_value
// rsp_*     out        rsp_valid/rsp_ready    noise_value (Q2.14)
// csr_*     in         csr_we                 csr_index, csr_data
//
// A sample occupies the octave sequencer for octave_count octaves, issued one octave per
// cycle while the pipeline is not held, into a nine-stage noise pipeline. The iterative
// divider (two quotient bits per cycle, plus hand-off) runs alongside, so the sequencer can
// take the next sample while the divider still works on the last one. A load waits until
// the sequencer is idle and no octave sits in the three table-read stages.
// Reset is synchronous; the table reads as the identity until entries are loaded.
// A sum waiting on a busy divider holds every stage; nothing is dropped or repeated.
module perlin_noise_3d_fbm_unit #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic [7:0]         req_entry_index,
   input  logic [7:0]         req_entry_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_noise_value,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import pnf_pkg::*;

   localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W = PROD_W + $clog2(MAX_OCTAVES) + 1;
   localparam int TOT_W = AMP_W + $clog2(MAX_OCTAVES);

   // configuration registers
   logic [3:0]       oct_ff;
   logic [PAR_W-1:0] pers_ff;
   logic [PAR_W-1:0] lac_ff;

   // octave sequencer
   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [AMP_W-1:0]   amp_ff, amp_in;
   logic [32:0]        amp_prod;
   logic [39:0]        freq_prod;
   logic [CNT_W-1:0]   n_clamp;

   // accumulator
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic [TOT_W-1:0]        tot_ff, tot_in;

   logic     adv;
   logic     seq_last;
   logic     take_sample;
   logic     take_load;
   logic     reads_pending;
   logic     tail_valid;
   tail_type tail;
   oct_type  cmd;
   logic     div_busy;
   logic     div_start;

   // configuration writes; an index past the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff  <= 4'd1;
         pers_ff <= 16'd32768;
         lac_ff  <= 16'd8192;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OCTAVES: oct_ff  <= csr_data[3:0];
            CSR_PERSIST: pers_ff <= csr_data;
            CSR_LACUN:   lac_ff  <= csr_data;
            default:     ;
         endcase
      end
   end

   // the whole pipeline holds while a finished sum waits for the divider
   assign adv      = !(tail_valid && tail.last && div_busy);
   assign seq_last = busy_ff && (k_ff == n_ff - 1'b1);

   // loads must not overtake octaves that still read the table
   always_comb begin
      if (req_op == OP_SAMPLE) begin
         req_ready = adv && (!busy_ff || seq_last);
      end else begin
         req_ready = adv && !busy_ff && !reads_pending;
      end
   end

   assign take_sample = req_valid && req_ready && (req_op == OP_SAMPLE);
   assign take_load   = req_valid && req_ready && (req_op == OP_LOAD);

   always_comb begin
      // clamp octave count into [1, MAX_OCTAVES]
      if (oct_ff == 4'd0) begin
         n_clamp = CNT_W'(1);
      end else if (32'(oct_ff) > MAX_OCTAVES) begin
         n_clamp = CNT_W'(MAX_OCTAVES);
      end else begin
         n_clamp = CNT_W'(oct_ff);
      end

      amp_prod  = 33'(amp_ff) * 33'(pers_ff);
      freq_prod = 40'(freq_ff) * 40'(lac_ff);

      busy_in = busy_ff;
      k_in    = k_ff;
      n_in    = n_ff;
      freq_in = freq_ff;
      amp_in  = amp_ff;
      if (take_sample) begin
         busy_in = 1'b1;
         k_in    = '0;
         n_in    = n_clamp;
         freq_in = FREQ_ONE;
         amp_in  = AMP_ONE;
      end else if (busy_ff && adv) begin
         // advance to the next octave
         busy_in = !seq_last;
         k_in    = k_ff + 1'b1;
         amp_in  = amp_prod[32:16];
         freq_in = (freq_prod[39:36] != 4'd0) ? FREQ_MAX : freq_prod[35:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      n_ff    <= n_in;
      freq_ff <= freq_in;
      amp_ff  <= amp_in;
      if (take_sample) begin
         cx_ff <= req_coord_x;
         cy_ff <= req_coord_y;
         cz_ff <= req_coord_z;
      end
   end

   assign cmd.cx    = cx_ff;
   assign cmd.cy    = cy_ff;
   assign cmd.cz    = cz_ff;
   assign cmd.freq  = freq_ff;
   assign cmd.amp   = amp_ff;
   assign cmd.first = (k_ff == '0);
   assign cmd.last  = seq_last;

   pnf_noise_pipe u_pipe (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .load_en       (take_load),
      .load_index    (req_entry_index),
      .load_value    (req_entry_value),
      .cmd_valid     (busy_ff),
      .cmd           (cmd),
      .reads_pending (reads_pending),
      .tail_valid    (tail_valid),
      .tail          (tail)
   );

   // sum weighted octaves and amplitudes; first octave restarts both
   always_comb begin
      acc_in = (tail.first ? SUM_W'(0) : acc_ff) + SUM_W'($signed(tail.prod));
      tot_in = (tail.first ? TOT_W'(0) : tot_ff) + TOT_W'(tail.amp);
   end

   always_ff @(posedge clock) begin
      if (adv && tail_valid) begin
         acc_ff <= acc_in;
         tot_ff <= tot_in;
      end
   end

   assign div_start = adv && tail_valid && tail.last;

   pnf_divider #(
      .NUM_W (SUM_W),
      .DEN_W (TOT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .num       (acc_in),
      .den       (tot_in),
      .busy      (div_busy),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .quotient  (rsp_noise_value)
   );

   // a load never lands while octaves still read the table
   assert property (@(posedge clock) disable iff (reset)
      take_load |-> !busy_ff && !reads_pending)
      else $error("table load during pending reads");

   // octave counter stays below the clamped count
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff < n_ff))
      else $error("octave counter overran");

   // a finished sum is only handed to an idle divider
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // the sequencer only runs octaves of a sample that was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(take_sample))
      else $error("sequencer started without a sample");

endmodule

`default_nettype wire
